// File: rtl/core/chip8_instruction_execute_macros.svh
// Assertion helpers used by the controller RTL.
`ifndef CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C8X_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define C8X_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/c8x_pkg.sv
`default_nettype none

package c8x_pkg;

    // Machine geometry
    localparam int MEMORY_BYTES  = 4096;
    localparam int STACK_DEPTH   = 16;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int MEM_AW        = $clog2(MEMORY_BYTES);
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ROW_AW        = $clog2(SCREEN_HEIGHT);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int VREGS         = 16;
    localparam logic [11:0] PC_RESET = 12'h200;

    // Item op codes
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_ROW  = 2'd2;

    // Fault codes
    localparam logic [1:0] F_NONE  = 2'd0;
    localparam logic [1:0] F_UNDEF = 2'd1;
    localparam logic [1:0] F_OVER  = 2'd2;
    localparam logic [1:0] F_UNDER = 2'd3;

    // Opcode groups (top nibble)
    localparam logic [3:0] G_SYS    = 4'h0;
    localparam logic [3:0] G_JP     = 4'h1;
    localparam logic [3:0] G_CALL   = 4'h2;
    localparam logic [3:0] G_SEQ_I  = 4'h3;
    localparam logic [3:0] G_SNE_I  = 4'h4;
    localparam logic [3:0] G_SEQ_R  = 4'h5;
    localparam logic [3:0] G_LD_I   = 4'h6;
    localparam logic [3:0] G_ADD_I  = 4'h7;
    localparam logic [3:0] G_ALU    = 4'h8;
    localparam logic [3:0] G_SNE_R  = 4'h9;
    localparam logic [3:0] G_LD_IDX = 4'hA;
    localparam logic [3:0] G_JP_V0  = 4'hB;
    localparam logic [3:0] G_RND    = 4'hC;
    localparam logic [3:0] G_DRW    = 4'hD;
    localparam logic [3:0] G_KEY    = 4'hE;
    localparam logic [3:0] G_MISC   = 4'hF;

    localparam logic [15:0] I_CLS = 16'h00E0;
    localparam logic [15:0] I_RET = 16'h00EE;

    // ALU sub-ops
    localparam logic [3:0] A_MOV  = 4'h0;
    localparam logic [3:0] A_OR   = 4'h1;
    localparam logic [3:0] A_AND  = 4'h2;
    localparam logic [3:0] A_XOR  = 4'h3;
    localparam logic [3:0] A_ADD  = 4'h4;
    localparam logic [3:0] A_SUB  = 4'h5;
    localparam logic [3:0] A_SHR  = 4'h6;
    localparam logic [3:0] A_SUBN = 4'h7;
    localparam logic [3:0] A_SHL  = 4'hE;

    // Key and misc sub-ops
    localparam logic [7:0] KEY_SKP   = 8'h9E;
    localparam logic [7:0] KEY_SKNP  = 8'hA1;
    localparam logic [7:0] M_GET_DT  = 8'h07;
    localparam logic [7:0] M_WAITKEY = 8'h0A;
    localparam logic [7:0] M_SET_DT  = 8'h15;
    localparam logic [7:0] M_SET_ST  = 8'h18;
    localparam logic [7:0] M_ADD_IDX = 8'h1E;
    localparam logic [7:0] M_FONT    = 8'h29;
    localparam logic [7:0] M_BCD     = 8'h33;
    localparam logic [7:0] M_STORE   = 8'h55;
    localparam logic [7:0] M_LOAD    = 8'h65;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] instruction;
        logic [7:0]  random_byte;
        logic [15:0] key_mask;
        logic [11:0] load_address;
        logic [7:0]  load_data;
        logic [4:0]  display_row;
    } t_in_item;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] index_value;
        logic [7:0]  flag_value;
        logic        draw_request;
        logic        waiting_for_key;
        logic [1:0]  fault_code;
        logic [63:0] row_pixels;
    } t_out_item;

    // Work class of the held item
    typedef enum logic [2:0] {
        KD_PLAIN,
        KD_FLAG,
        KD_DRAW,
        KD_BCD,
        KD_STORE,
        KD_LOAD,
        KD_ROW
    } t_kind;

    typedef struct packed {
        logic accept;
        logic rd_x;
        logic rd_y;
        logic exec;
        logic flag_wr;
        logic draw_rd;
        logic draw_wr;
        logic loop_rd;
        logic loop_wr;
        logic bcd_wr;
        logic row_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  loop_last;
        logic  draw_done;
        logic  out_busy;
    } t_sts;

    // Split a byte into hundreds, tens, ones (reciprocal multiply for tens)
    function automatic logic [11:0] c8x_bcd(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [7:0]  o;
        if (v >= 8'd200) begin
            h = 2'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 2'd1;
            r = v - 8'd100;
        end else begin
            h = 2'd0;
            r = v;
        end
        p = {8'b0, r[6:0]} * 15'd205;
        t = p[14:11];
        o = r - ({1'b0, t, 3'b0} + {3'b0, t, 1'b0});
        return {2'b0, h, t, o[3:0]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/c8x_ram.sv
`default_nettype none

module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/c8x_dp.sv
`default_nettype none

module c8x_dp import c8x_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    // Held item and architectural state
    t_in_item    r_in;
    logic [11:0] r_pc;
    logic [15:0] r_i;
    logic [7:0]  r_vf;
    logic [7:0]  r_dt;
    logic [SP_W-1:0] r_sp;
    logic [11:0] r_stack [STACK_DEPTH];
    logic [VREGS-1:0] r_v_valid;
    logic        r_v_rv;
    logic [SCREEN_HEIGHT-1:0] r_f_valid;

    // Per-item working registers
    logic [7:0]  r_vx;
    logic [7:0]  r_vy;
    logic        r_flag;
    logic        r_hit;
    logic [3:0]  r_cnt;
    logic        r_draw;
    logic        r_wait;
    logic [1:0]  r_fault;
    logic [SCREEN_WIDTH-1:0] r_row;
    t_out_item   r_out;
    logic        r_out_valid;

    // Decode fields
    logic [15:0] ins;
    logic [3:0]  grp, x, y, n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    t_kind       kind;

    assign ins = r_in.instruction;
    assign grp = ins[15:12];
    assign x   = ins[11:8];
    assign y   = ins[7:4];
    assign n   = ins[3:0];
    assign nn  = ins[7:0];
    assign nnn = ins[11:0];

    // RAM ports
    logic        v_we;
    logic [3:0]  v_waddr, v_raddr;
    logic [7:0]  v_wdata, v_rdata, v_eff;
    logic        m_we;
    logic [MEM_AW-1:0] m_waddr, m_addr_i;
    logic [7:0]  m_wdata, m_rdata;
    logic        f_we;
    logic [ROW_AW-1:0] f_raddr, drow;
    logic [SCREEN_WIDTH-1:0] f_wdata, f_rdata, f_old, sprite;
    logic [ROW_AW:0] row_sum;

    // Execute results
    logic [11:0] e_pc;
    logic [1:0]  e_fault;
    logic        e_vwr, e_iwr, e_flag, e_push, e_dtwr, e_cls, e_draw, e_wait;
    logic [7:0]  e_vdata;
    logic [15:0] e_idata;
    logic [SP_W-1:0] e_sp, sp_dec;
    logic [8:0]  sum9;
    logic [16:0] isum17;
    logic        keybit;
    logic [3:0]  hikey;
    logic [11:0] stack_top;
    logic [11:0] digits;
    logic [7:0]  digit;

    // Classify the held item
    always_comb begin
        kind = KD_PLAIN;
        if (r_in.op == OP_ROW) begin
            kind = KD_ROW;
        end else if (r_in.op == OP_EXEC) begin
            unique case (grp)
                G_ALU: begin
                    if (n == A_ADD || n == A_SUB || n == A_SHR || n == A_SUBN || n == A_SHL)
                        kind = KD_FLAG;
                end
                G_DRW: kind = KD_DRAW;
                G_MISC: begin
                    if (nn == M_ADD_IDX) kind = KD_FLAG;
                    else if (nn == M_BCD) kind = KD_BCD;
                    else if (nn == M_STORE) kind = KD_STORE;
                    else if (nn == M_LOAD) kind = KD_LOAD;
                end
                default: ;
            endcase
        end
    end

    assign v_eff     = r_v_rv ? v_rdata : 8'h00;
    assign sum9      = {1'b0, r_vx} + {1'b0, v_eff};
    assign isum17    = {1'b0, r_i} + {9'b0, r_vx};
    assign keybit    = r_in.key_mask[r_vx[3:0]];
    assign sp_dec    = r_sp - 1'b1;
    assign stack_top = r_stack[sp_dec[STK_AW-1:0]];

    // Highest pressed key
    always_comb begin
        hikey = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (r_in.key_mask[k]) hikey = 4'(k);
        end
    end

    // Combinational effects of one instruction; vy is the live read data
    always_comb begin
        e_pc    = r_pc + 12'd2;
        e_fault = F_NONE;
        e_vwr   = 1'b0;
        e_vdata = 8'h00;
        e_iwr   = 1'b0;
        e_idata = r_i;
        e_flag  = 1'b0;
        e_sp    = r_sp;
        e_push  = 1'b0;
        e_dtwr  = 1'b0;
        e_cls   = 1'b0;
        e_draw  = 1'b0;
        e_wait  = 1'b0;
        if (r_in.op != OP_EXEC) begin
            e_pc = r_pc;
        end else begin
            unique case (grp)
                G_SYS: begin
                    if (ins == I_CLS) begin
                        e_cls  = 1'b1;
                        e_draw = 1'b1;
                    end else if (ins == I_RET) begin
                        if (r_sp == '0) begin
                            e_fault = F_UNDER;
                        end else begin
                            e_sp = sp_dec;
                            e_pc = stack_top + 12'd2;
                        end
                    end else begin
                        e_fault = F_UNDEF;
                    end
                end
                G_JP: e_pc = nnn;
                G_CALL: begin
                    if (r_sp >= SP_W'(STACK_DEPTH)) begin
                        e_fault = F_OVER;
                    end else begin
                        e_push = 1'b1;
                        e_sp   = r_sp + 1'b1;
                        e_pc   = nnn;
                    end
                end
                G_SEQ_I: if (r_vx == nn) e_pc = r_pc + 12'd4;
                G_SNE_I: if (r_vx != nn) e_pc = r_pc + 12'd4;
                G_SEQ_R: if (r_vx == v_eff) e_pc = r_pc + 12'd4;
                G_SNE_R: if (r_vx != v_eff) e_pc = r_pc + 12'd4;
                G_LD_I: begin
                    e_vwr   = 1'b1;
                    e_vdata = nn;
                end
                G_ADD_I: begin
                    e_vwr   = 1'b1;
                    e_vdata = r_vx + nn;
                end
                G_ALU: begin
                    e_vwr = 1'b1;
                    unique case (n)
                        A_MOV: e_vdata = v_eff;
                        A_OR:  e_vdata = r_vx | v_eff;
                        A_AND: e_vdata = r_vx & v_eff;
                        A_XOR: e_vdata = r_vx ^ v_eff;
                        A_ADD: begin
                            e_vdata = sum9[7:0];
                            e_flag  = sum9[8];
                        end
                        A_SUB: begin
                            e_vdata = r_vx - v_eff;
                            e_flag  = (v_eff <= r_vx);
                        end
                        A_SHR: begin
                            e_vdata = {1'b0, r_vx[7:1]};
                            e_flag  = r_vx[0];
                        end
                        A_SUBN: begin
                            e_vdata = v_eff - r_vx;
                            e_flag  = (r_vx <= v_eff);
                        end
                        A_SHL: begin
                            e_vdata = {r_vx[6:0], 1'b0};
                            e_flag  = r_vx[7];
                        end
                        default: begin
                            e_vwr   = 1'b0;
                            e_fault = F_UNDEF;
                        end
                    endcase
                end
                G_LD_IDX: begin
                    e_iwr   = 1'b1;
                    e_idata = {4'b0, nnn};
                end
                G_JP_V0: e_pc = nnn + {4'b0, v_eff};
                G_RND: begin
                    e_vwr   = 1'b1;
                    e_vdata = r_in.random_byte & nn;
                end
                G_DRW: e_draw = 1'b1;
                G_KEY: begin
                    if (nn == KEY_SKP) begin
                        if (keybit) e_pc = r_pc + 12'd4;
                    end else if (nn == KEY_SKNP) begin
                        if (!keybit) e_pc = r_pc + 12'd4;
                    end else begin
                        e_fault = F_UNDEF;
                    end
                end
                G_MISC: begin
                    unique case (nn)
                        M_GET_DT: begin
                            e_vwr   = 1'b1;
                            e_vdata = r_dt;
                        end
                        M_WAITKEY: begin
                            if (r_in.key_mask == 16'h0000) begin
                                e_wait = 1'b1;
                                e_pc   = r_pc;
                            end else begin
                                e_vwr   = 1'b1;
                                e_vdata = {4'b0, hikey};
                            end
                        end
                        M_SET_DT: e_dtwr = 1'b1;
                        M_SET_ST: ;
                        M_ADD_IDX: begin
                            e_iwr   = 1'b1;
                            e_idata = isum17[15:0];
                            e_flag  = (isum17 > 17'h00FFF);
                        end
                        M_FONT: begin
                            e_iwr   = 1'b1;
                            e_idata = {6'b0, r_vx, 2'b0} + {8'b0, r_vx};
                        end
                        M_BCD, M_STORE, M_LOAD: ;
                        default: e_fault = F_UNDEF;
                    endcase
                end
            endcase
        end
    end

    // Address generation
    assign m_addr_i = r_i[MEM_AW-1:0] + MEM_AW'(r_cnt);
    assign row_sum  = {1'b0, r_vy[ROW_AW-1:0]} + (ROW_AW+1)'(r_cnt);
    assign drow     = row_sum[ROW_AW-1:0];
    assign digits   = c8x_bcd(r_vx);

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    digit = {4'b0, digits[11:8]};
            2'd1:    digit = {4'b0, digits[7:4]};
            default: digit = {4'b0, digits[3:0]};
        endcase
    end

    // Register file port steering
    assign v_raddr = i_cmd.rd_x ? x :
                     i_cmd.rd_y ? ((grp == G_JP_V0) ? 4'h0 : y) : r_cnt;
    assign v_we    = (i_cmd.exec && e_vwr) || i_cmd.flag_wr ||
                     (i_cmd.loop_wr && kind == KD_LOAD);
    assign v_waddr = i_cmd.flag_wr ? 4'hF : (i_cmd.loop_wr ? r_cnt : x);
    assign v_wdata = i_cmd.flag_wr ? ((kind == KD_DRAW) ? {7'b0, r_hit} : {7'b0, r_flag}) :
                     (i_cmd.loop_wr ? m_rdata : e_vdata);

    // Main memory port steering
    assign m_we    = (i_cmd.exec && r_in.op == OP_LOAD) || i_cmd.bcd_wr ||
                     (i_cmd.loop_wr && kind == KD_STORE);
    assign m_waddr = (i_cmd.bcd_wr || i_cmd.loop_wr) ? m_addr_i : r_in.load_address;
    assign m_wdata = i_cmd.bcd_wr ? digit : (i_cmd.loop_wr ? v_eff : r_in.load_data);

    // Framebuffer XOR merge
    assign f_raddr = i_cmd.draw_rd ? drow : r_in.display_row;
    assign f_old   = r_f_valid[drow] ? f_rdata : '0;
    assign sprite  = {m_rdata, {(SCREEN_WIDTH-8){1'b0}}} >> r_vx[COL_W-1:0];
    assign f_we    = i_cmd.draw_wr;
    assign f_wdata = f_old ^ sprite;

    c8x_ram #(.WIDTH(8), .DEPTH(VREGS)) u_vregs (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_addr_i),
        .o_rdata (m_rdata)
    );

    c8x_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_frame (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (drow),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // Push the return address
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && e_push) begin
            r_stack[r_sp[STK_AW-1:0]] <= r_pc;
        end
    end

    // State and per-item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RESET;
            r_i         <= '0;
            r_vf        <= '0;
            r_dt        <= '0;
            r_sp        <= '0;
            r_v_valid   <= '0;
            r_f_valid   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v_rv <= r_v_valid[v_raddr];

            if (i_cmd.accept) begin
                r_in    <= i_in_item;
                r_draw  <= 1'b0;
                r_wait  <= 1'b0;
                r_fault <= F_NONE;
                r_row   <= '0;
            end

            if (i_cmd.rd_y) begin
                r_vx <= v_eff;
            end

            if (i_cmd.exec) begin
                r_pc    <= e_pc;
                r_sp    <= e_sp;
                r_flag  <= e_flag;
                r_draw  <= e_draw;
                r_wait  <= e_wait;
                r_fault <= e_fault;
                r_vy    <= v_eff;
                r_cnt   <= 4'd0;
                r_hit   <= 1'b0;
                if (e_iwr) r_i <= e_idata;
                if (e_dtwr) r_dt <= r_vx;
                if (e_cls) r_f_valid <= '0;
            end

            // Track written registers and mirror VF
            if (v_we) begin
                r_v_valid[v_waddr] <= 1'b1;
                if (v_waddr == 4'hF) r_vf <= v_wdata;
            end

            if (i_cmd.draw_wr) begin
                r_f_valid[drow] <= 1'b1;
                r_hit <= r_hit | (|(f_old & sprite));
                r_cnt <= r_cnt + 4'd1;
            end

            if (i_cmd.loop_wr) begin
                r_cnt <= r_cnt + 4'd1;
                if (o_sts.loop_last) r_i <= r_i + {11'b0, x} + 16'd1;
            end

            if (i_cmd.bcd_wr) begin
                r_cnt <= r_cnt + 4'd1;
            end

            if (i_cmd.row_rd) begin
                r_row <= r_f_valid[r_in.display_row] ? f_rdata : '0;
            end

            // Output register
            if (i_cmd.finish) begin
                r_out.program_counter <= r_pc;
                r_out.index_value     <= r_i;
                r_out.flag_value      <= r_vf;
                r_out.draw_request    <= r_draw;
                r_out.waiting_for_key <= r_wait;
                r_out.fault_code      <= r_fault;
                r_out.row_pixels      <= r_row;
                r_out_valid           <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status to the controller
    assign o_sts.kind      = kind;
    assign o_sts.loop_last = (kind == KD_STORE || kind == KD_LOAD) ? (r_cnt == x) :
                             (r_cnt == 4'd2);
    assign o_sts.draw_done = (r_cnt == n) || row_sum[ROW_AW];
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/core/c8x_ctrl.sv
`default_nettype none
`include "chip8_instruction_execute_macros.svh"

module c8x_ctrl import c8x_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_RDX  = 12'b0000_0000_0010,
        S_RDY  = 12'b0000_0000_0100,
        S_EXEC = 12'b0000_0000_1000,
        S_FLAG = 12'b0000_0001_0000,
        S_DRD  = 12'b0000_0010_0000,
        S_DWR  = 12'b0000_0100_0000,
        S_MRD  = 12'b0000_1000_0000,
        S_MWR  = 12'b0001_0000_0000,
        S_BCD  = 12'b0010_0000_0000,
        S_ROW  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_RDX;
            end
            S_RDX: begin
                o_cmd.rd_x = 1'b1;
                n_state    = S_RDY;
            end
            S_RDY: begin
                o_cmd.rd_y = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_sts.kind)
                    KD_FLAG:  n_state = S_FLAG;
                    KD_DRAW:  n_state = S_DRD;
                    KD_BCD:   n_state = S_BCD;
                    KD_STORE: n_state = S_MRD;
                    KD_LOAD:  n_state = S_MRD;
                    KD_ROW:   n_state = S_ROW;
                    default:  n_state = S_DONE;
                endcase
            end
            S_FLAG: begin
                o_cmd.flag_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DRD: begin
                if (i_sts.draw_done) begin
                    n_state = S_FLAG;
                end else begin
                    o_cmd.draw_rd = 1'b1;
                    n_state       = S_DWR;
                end
            end
            S_DWR: begin
                o_cmd.draw_wr = 1'b1;
                n_state       = S_DRD;
            end
            S_MRD: begin
                o_cmd.loop_rd = 1'b1;
                n_state       = S_MWR;
            end
            S_MWR: begin
                o_cmd.loop_wr = 1'b1;
                n_state       = i_sts.loop_last ? S_DONE : S_MRD;
            end
            S_BCD: begin
                o_cmd.bcd_wr = 1'b1;
                if (i_sts.loop_last) n_state = S_DONE;
            end
            S_ROW: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `C8X_ASSERT_NOW(a_finish_free, i_clk, i_rst_n, o_cmd.finish, !i_sts.out_busy, "finish while output held")
    `C8X_ASSERT_NEXT(a_exec_after_y, i_clk, i_rst_n, o_cmd.rd_y, o_cmd.exec, "exec did not follow operand read")
    `C8X_ASSERT_NEXT(a_draw_pair, i_clk, i_rst_n, o_cmd.draw_rd, o_cmd.draw_wr, "draw read without merge")
    `C8X_ASSERT_NEXT(a_loop_pair, i_clk, i_rst_n, o_cmd.loop_rd, o_cmd.loop_wr, "loop read without write")

endmodule

`default_nettype wire

// File: rtl/core/chip8_instruction_execute.sv
// Channel  Direction  Handshake           Payload
// in       input      i_in_valid/o_in_stall   i_in_item  (t_in_item)
// out      output     o_out_valid/i_out_stall o_out_item (t_out_item)
//
// One item at a time: operand reads, execute, then result. DXYN adds a read
// and XOR merge per drawn row and a VF write; FX55/FX65 a read and write per
// byte V0..VX; FX33 a write per digit; row reads a framebuffer read and flag ops
// a VF write. These go through the register file, main memory and framebuffer RAMs.
// Synchronous reset clears control, registers and framebuffer valid bits at once.
// A new item is taken while a finished result waits on a stalled output.
`default_nettype none

module chip8_instruction_execute import c8x_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    c8x_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Machine state and storage
    c8x_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
